// ----- rtl/core/mcf_pkg.sv -----
// mcf_pkg: shared types, codes and the CRC-16 byte step for the motor command framer.
// No dependencies; imported by every module of the block.
`default_nettype none

package mcf_pkg;

    // Frame and acknowledgment constants
    localparam logic [15:0] CRC_POLY   = 16'h1021;
    localparam logic [7:0]  CMD_MOTOR1 = 8'd35;
    localparam logic [7:0]  CMD_MOTOR2 = 8'd36;
    localparam logic [7:0]  ACK_BYTE   = 8'hFF;
    localparam logic [15:0] ACK_TICKS_RESET = 16'd10;

    // Frame byte positions
    localparam int          FRAME_LEN  = 8;
    localparam int          IDX_W      = $clog2(FRAME_LEN);
    localparam logic [IDX_W-1:0] IDX_CRC_HI = IDX_W'(6);
    localparam logic [IDX_W-1:0] IDX_LAST   = IDX_W'(FRAME_LEN - 1);

    // Job queue sizing
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = Q_AW + 1;

    // Input action codes (code 3 is unused)
    typedef enum logic [1:0] {
        ACT_SEND = 2'd0,
        ACT_RESP = 2'd1,
        ACT_TICK = 2'd2
    } t_action;

    // Result kinds
    typedef enum logic {
        KIND_FRAME  = 1'b0,
        KIND_STATUS = 1'b1
    } t_kind;

    // Status codes
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_BAD     = 2'd1,
        ST_TIMEOUT = 2'd2
    } t_status;

    // Input item
    typedef struct packed {
        logic [1:0]         action;
        logic               motor;
        logic [7:0]         target_address;
        logic signed [31:0] speed;
        logic [7:0]         rx_byte;
    } t_cmd_in;

    // Result item
    typedef struct packed {
        logic       kind;
        logic [7:0] tx_byte;
        logic       last;
        logic [1:0] status;
    } t_res_out;

    // Queue entry between front and back
    typedef struct packed {
        logic        is_status;
        logic        motor;
        logic [7:0]  addr;
        logic [31:0] speed;
        logic [1:0]  status;
    } t_job;

    // CRC-16/XMODEM over one byte, MSB first
    function automatic logic [15:0] crc16_step(input logic [15:0] crc_in,
                                               input logic [7:0] data);
        logic [15:0] c;
        c = crc_in ^ {data, 8'h00};
        for (int b = 0; b < 8; b++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/mcf_front.sv -----
// mcf_front: accepts input items, tracks the acknowledgment wait and timeout,
// and pushes frame or status jobs to the queue. Depends on mcf_pkg.
`default_nettype none

module mcf_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_cfg_we,
    input  wire logic [15:0]     i_cfg_data,
    input  wire logic            i_accept,
    input  wire mcf_pkg::t_cmd_in i_cmd,
    output logic                 o_push,
    output mcf_pkg::t_job        o_job
);
    import mcf_pkg::*;

    logic [15:0] r_ack_ticks;
    logic        r_awaiting;
    logic        n_awaiting;
    logic [15:0] r_left;
    logic [15:0] n_left;

    // Classify the accepted transfer and update the wait state
    always_comb begin
        n_awaiting    = r_awaiting;
        n_left        = r_left;
        o_push        = 1'b0;
        o_job         = '0;
        o_job.motor   = i_cmd.motor;
        o_job.addr    = i_cmd.target_address;
        o_job.speed   = i_cmd.speed;
        if (i_accept) begin
            unique case (i_cmd.action)
                ACT_SEND: begin
                    o_push     = 1'b1;
                    n_awaiting = 1'b1;
                    n_left     = r_ack_ticks;
                end
                ACT_RESP: begin
                    if (r_awaiting) begin
                        o_push          = 1'b1;
                        o_job.is_status = 1'b1;
                        o_job.status    = (i_cmd.rx_byte == ACK_BYTE) ? ST_OK : ST_BAD;
                        n_awaiting      = 1'b0;
                        n_left          = '0;
                    end
                end
                ACT_TICK: begin
                    if (r_awaiting) begin
                        // zero in the counter behaves like one
                        if (r_left <= 16'd1) begin
                            o_push          = 1'b1;
                            o_job.is_status = 1'b1;
                            o_job.status    = ST_TIMEOUT;
                            n_awaiting      = 1'b0;
                            n_left          = '0;
                        end else begin
                            n_left = r_left - 16'd1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // State and timeout register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_awaiting  <= 1'b0;
            r_left      <= '0;
            r_ack_ticks <= ACK_TICKS_RESET;
        end else begin
            r_awaiting <= n_awaiting;
            r_left     <= n_left;
            if (i_cfg_we) begin
                r_ack_ticks <= i_cfg_data;
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/mcf_queue.sv -----
// mcf_queue: short job FIFO between the front and the back.
// Depends on mcf_pkg for the job type and depth.
`default_nettype none

module mcf_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire mcf_pkg::t_job i_job,
    input  wire logic          i_pop,
    output mcf_pkg::t_job      o_head,
    output logic               o_empty,
    output logic               o_full
);
    import mcf_pkg::*;

    t_job            r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wr_ptr;
    logic [Q_AW-1:0] r_rd_ptr;
    logic [Q_CW-1:0] r_count;
    logic [Q_CW-1:0] n_count;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == Q_CW'(Q_DEPTH));
    assign o_head  = r_mem[r_rd_ptr];

    // Occupancy
    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    // Pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/mcf_back.sv -----
// mcf_back: plays queue jobs out as result items, one per cycle while the result
// channel is ready, with the CRC-16 built a byte at a time. Depends on mcf_pkg.
`default_nettype none

module mcf_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire mcf_pkg::t_job i_head,
    input  wire logic          i_empty,
    output logic               o_pop,
    output logic               o_res_valid,
    input  wire logic          i_res_ready,
    output mcf_pkg::t_res_out  o_res
);
    import mcf_pkg::*;

    logic             r_valid;
    logic             n_valid;
    t_res_out         r_res;
    t_res_out         n_res;
    logic [IDX_W-1:0] r_idx;
    logic [IDX_W-1:0] n_idx;
    logic [15:0]      r_crc;
    logic [15:0]      n_crc;
    logic             w_advance;
    logic             w_take;
    logic [7:0]       w_byte;

    assign w_advance = !r_valid || i_res_ready;
    assign w_take    = w_advance && !i_empty;

    // Frame byte at the current position
    always_comb begin
        case (r_idx)
            3'd0:    w_byte = i_head.addr;
            3'd1:    w_byte = i_head.motor ? CMD_MOTOR2 : CMD_MOTOR1;
            3'd2:    w_byte = i_head.speed[31:24];
            3'd3:    w_byte = i_head.speed[23:16];
            3'd4:    w_byte = i_head.speed[15:8];
            3'd5:    w_byte = i_head.speed[7:0];
            3'd6:    w_byte = r_crc[15:8];
            default: w_byte = r_crc[7:0];
        endcase
    end

    // Output stage, position counter and running CRC
    always_comb begin
        n_valid = w_advance ? w_take : r_valid;
        n_res   = r_res;
        n_idx   = r_idx;
        n_crc   = r_crc;
        o_pop   = 1'b0;
        if (w_take) begin
            if (i_head.is_status) begin
                n_res.kind    = KIND_STATUS;
                n_res.tx_byte = '0;
                n_res.last    = 1'b1;
                n_res.status  = i_head.status;
                o_pop         = 1'b1;
            end else begin
                n_res.kind    = KIND_FRAME;
                n_res.tx_byte = w_byte;
                n_res.last    = (r_idx == IDX_LAST);
                n_res.status  = ST_OK;
                if (r_idx < IDX_CRC_HI) begin
                    n_crc = crc16_step((r_idx == '0) ? 16'h0000 : r_crc, w_byte);
                end
                if (r_idx == IDX_LAST) begin
                    o_pop = 1'b1;
                    n_idx = '0;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            r_valid <= n_valid;
            r_idx   <= n_idx;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_res <= n_res;
        r_crc <= n_crc;
    end

    assign o_res_valid = r_valid;
    assign o_res       = r_res;

endmodule

`default_nettype wire

// ----- rtl/core/motor_command_framer_crc16.sv -----
// motor_command_framer_crc16: top level of the motor speed command framer.
// Depends on mcf_pkg, mcf_front, mcf_queue and mcf_back.
//
//   channel   direction  handshake                   payload
//   cmd       in         i_cmd_valid / o_cmd_ready   i_cmd (t_cmd_in)
//   res       out        o_res_valid / i_res_ready   o_res (t_res_out)
//   cfg       in         i_cfg_we                    i_cfg_data (ack timeout ticks)
//
// An input transfer is taken every cycle while the four-entry job queue has room.
// A send command gives eight result bytes, one per cycle from the back end's
// output register while the result channel is ready; a status gives one item.
// Responses or ticks while no acknowledgment is awaited, ticks that do not end
// the wait, and unused actions produce no result.
// Reset is synchronous and active low; it empties the queue and clears the wait.
// A stalled result holds in the output register while the front keeps accepting.
`default_nettype none

module motor_command_framer_crc16 (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [15:0]       i_cfg_data,
    input  wire logic              i_cmd_valid,
    output logic                   o_cmd_ready,
    input  wire mcf_pkg::t_cmd_in  i_cmd,
    output logic                   o_res_valid,
    input  wire logic              i_res_ready,
    output mcf_pkg::t_res_out      o_res
);
    import mcf_pkg::*;

    logic w_accept;
    logic w_push;
    logic w_pop;
    logic w_empty;
    logic w_full;
    t_job w_job;
    t_job w_head;

    assign o_cmd_ready = !w_full;
    assign w_accept    = i_cmd_valid && o_cmd_ready;

    mcf_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_accept   (w_accept),
        .i_cmd      (i_cmd),
        .o_push     (w_push),
        .o_job      (w_job)
    );

    mcf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_job),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_empty (w_empty),
        .o_full  (w_full)
    );

    mcf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (w_head),
        .i_empty     (w_empty),
        .o_pop       (w_pop),
        .o_res_valid (o_res_valid),
        .i_res_ready (i_res_ready),
        .o_res       (o_res)
    );

    // A status result is always a single, last item with no frame byte
    a_status_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.kind == KIND_STATUS) |-> (o_res.last && o_res.tx_byte == 8'h00))
        else $error("status result malformed");

    // Frame bytes carry a zero status
    a_frame_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.kind == KIND_FRAME) |-> (o_res.status == ST_OK))
        else $error("frame byte with nonzero status");

    // A frame is never interleaved with a status
    a_frame_contig: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && i_res_ready && o_res.kind == KIND_FRAME && !o_res.last)
        |=> (!o_res_valid || o_res.kind == KIND_FRAME))
        else $error("frame interrupted");

    // The queue never takes a job when full
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_full |-> !w_push)
        else $error("job pushed into full queue");

endmodule

`default_nettype wire
